FILE: src/slic_pkg.sv
package slic_pkg;

    // Result codes of one segment pair.
    typedef enum logic [1:0] {
        OUT_HIT      = 2'd0,
        OUT_PARALLEL = 2'd1,
        OUT_NOT_INT  = 2'd2,
        OUT_OUTSIDE  = 2'd3
    } t_outcome;

endpackage

FILE: src/slic_front.sv
module slic_front #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [COORD_WIDTH-1:0]       i_ax1,
    input  logic [COORD_WIDTH-1:0]       i_ay1,
    input  logic [COORD_WIDTH-1:0]       i_ax2,
    input  logic [COORD_WIDTH-1:0]       i_ay2,
    input  logic [COORD_WIDTH-1:0]       i_bx1,
    input  logic [COORD_WIDTH-1:0]       i_by1,
    input  logic [COORD_WIDTH-1:0]       i_bx2,
    input  logic [COORD_WIDTH-1:0]       i_by2,
    output logic                         o_valid,
    output logic [3*COORD_WIDTH+2:0]     o_num_x,
    output logic [3*COORD_WIDTH+2:0]     o_num_y,
    output logic [2*COORD_WIDTH+2:0]     o_den,
    output logic [4*COORD_WIDTH+2:0]     o_tag
);
    localparam int W    = COORD_WIDTH;
    localparam int DXW  = W + 1;
    localparam int PW   = 2 * W;
    localparam int PDW  = 2 * W + 2;
    localparam int DENW = 2 * W + 3;
    localparam int CW   = 2 * W + 1;
    localparam int MW   = 3 * W + 2;
    localparam int NW   = 3 * W + 3;
    localparam int SW   = 4 * W;

    // Stage 1: differences, coordinate products and the span window.
    logic                  r1_v;
    logic signed [DXW-1:0] r1_dxa, r1_dya, r1_dxb, r1_dyb;
    logic [PW-1:0]         r1_pa, r1_pb, r1_pc, r1_pd;
    logic [SW-1:0]         r1_span;
    // Stage 2.
    logic                  r2_v;
    logic signed [DXW-1:0] r2_dxa, r2_dya, r2_dxb, r2_dyb;
    logic signed [PDW-1:0] r2_pd1, r2_pd2;
    logic signed [CW-1:0]  r2_c1, r2_c2;
    logic [SW-1:0]         r2_span;
    // Stage 3.
    logic                  r3_v;
    logic signed [DENW-1:0] r3_den;
    logic signed [MW-1:0]  r3_m1, r3_m2, r3_m3, r3_m4;
    logic [SW-1:0]         r3_span;
    // Stage 4.
    logic                  r4_v;
    logic signed [DENW-1:0] r4_den;
    logic signed [NW-1:0]  r4_nx, r4_ny;
    logic [SW-1:0]         r4_span;
    // Stage 5: sign normalised.
    logic                  r5_v;
    logic [NW-1:0]         r5_nx, r5_ny;
    logic [DENW-1:0]       r5_den;
    logic                  r5_par, r5_negx, r5_negy;
    logic [SW-1:0]         r5_span;

    logic [W-1:0] xlo, xhi, ylo, yhi;
    logic [W-1:0] amnx, amxx, bmnx, bmxx, amny, amxy, bmny, bmxy;
    logic signed [NW-1:0]   nxs, nys;
    logic signed [DENW-1:0] dens;

    always_comb begin
        amnx = (i_ax1 < i_ax2) ? i_ax1 : i_ax2;
        amxx = (i_ax1 < i_ax2) ? i_ax2 : i_ax1;
        bmnx = (i_bx1 < i_bx2) ? i_bx1 : i_bx2;
        bmxx = (i_bx1 < i_bx2) ? i_bx2 : i_bx1;
        amny = (i_ay1 < i_ay2) ? i_ay1 : i_ay2;
        amxy = (i_ay1 < i_ay2) ? i_ay2 : i_ay1;
        bmny = (i_by1 < i_by2) ? i_by1 : i_by2;
        bmxy = (i_by1 < i_by2) ? i_by2 : i_by1;
        xlo  = (amnx > bmnx) ? amnx : bmnx;
        xhi  = (amxx < bmxx) ? amxx : bmxx;
        ylo  = (amny > bmny) ? amny : bmny;
        yhi  = (amxy < bmxy) ? amxy : bmxy;
    end

    always_comb begin
        if (r4_den < 0) begin
            dens = -r4_den;
            nxs  = -r4_nx;
            nys  = -r4_ny;
        end else begin
            dens = r4_den;
            nxs  = r4_nx;
            nys  = r4_ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dxa  <= $signed({1'b0, i_ax1}) - $signed({1'b0, i_ax2});
            r1_dya  <= $signed({1'b0, i_ay1}) - $signed({1'b0, i_ay2});
            r1_dxb  <= $signed({1'b0, i_bx1}) - $signed({1'b0, i_bx2});
            r1_dyb  <= $signed({1'b0, i_by1}) - $signed({1'b0, i_by2});
            r1_pa   <= i_ax1 * i_ay2;
            r1_pb   <= i_ay1 * i_ax2;
            r1_pc   <= i_bx1 * i_by2;
            r1_pd   <= i_by1 * i_bx2;
            r1_span <= {xlo, xhi, ylo, yhi};

            r2_dxa  <= r1_dxa;
            r2_dya  <= r1_dya;
            r2_dxb  <= r1_dxb;
            r2_dyb  <= r1_dyb;
            r2_pd1  <= r1_dxa * r1_dyb;
            r2_pd2  <= r1_dya * r1_dxb;
            r2_c1   <= $signed({1'b0, r1_pa}) - $signed({1'b0, r1_pb});
            r2_c2   <= $signed({1'b0, r1_pc}) - $signed({1'b0, r1_pd});
            r2_span <= r1_span;

            r3_den  <= DENW'(r2_pd1) - DENW'(r2_pd2);
            r3_m1   <= MW'(r2_c1) * MW'(r2_dxb);
            r3_m2   <= MW'(r2_dxa) * MW'(r2_c2);
            r3_m3   <= MW'(r2_c1) * MW'(r2_dyb);
            r3_m4   <= MW'(r2_dya) * MW'(r2_c2);
            r3_span <= r2_span;

            r4_den  <= r3_den;
            r4_nx   <= NW'(r3_m1) - NW'(r3_m2);
            r4_ny   <= NW'(r3_m3) - NW'(r3_m4);
            r4_span <= r3_span;

            r5_den  <= dens;
            r5_nx   <= nxs;
            r5_ny   <= nys;
            r5_par  <= (r4_den == '0);
            r5_negx <= nxs[NW-1];
            r5_negy <= nys[NW-1];
            r5_span <= r4_span;
        end
    end

    assign o_valid = r5_v;
    assign o_num_x = r5_nx;
    assign o_num_y = r5_ny;
    assign o_den   = r5_den;
    assign o_tag   = {r5_par, r5_negx, r5_negy, r5_span};
endmodule

FILE: src/slic_div.sv
module slic_div #(
    parameter int NW = 27,
    parameter int DW = 19,
    parameter int TW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num_x,
    input  logic [NW-1:0] i_num_y,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo_x,
    output logic [NW-1:0] o_quo_y,
    output logic          o_rem_zero_x,
    output logic          o_rem_zero_y,
    output logic [TW-1:0] o_tag
);
    // One quotient bit per stage, both lanes share the divisor.
    logic          r_v   [NW];
    logic [DW-1:0] r_rx  [NW];
    logic [DW-1:0] r_ry  [NW];
    logic [NW-1:0] r_qx  [NW];
    logic [NW-1:0] r_qy  [NW];
    logic [DW-1:0] r_d   [NW];
    logic [TW-1:0] r_tag [NW];

    genvar g;
    generate
        for (g = 0; g < NW; g++) begin : g_stage
            logic          v_in;
            logic [DW-1:0] rx_in, ry_in, d_in;
            logic [NW-1:0] qx_in, qy_in;
            logic [TW-1:0] tag_in;
            logic [DW:0]   tx, ty;
            logic          gex, gey;

            if (g == 0) begin : g_first
                assign v_in   = i_valid;
                assign rx_in  = '0;
                assign ry_in  = '0;
                assign qx_in  = i_num_x;
                assign qy_in  = i_num_y;
                assign d_in   = i_den;
                assign tag_in = i_tag;
            end else begin : g_rest
                assign v_in   = r_v[g-1];
                assign rx_in  = r_rx[g-1];
                assign ry_in  = r_ry[g-1];
                assign qx_in  = r_qx[g-1];
                assign qy_in  = r_qy[g-1];
                assign d_in   = r_d[g-1];
                assign tag_in = r_tag[g-1];
            end

            assign tx  = {rx_in, qx_in[NW-1]};
            assign ty  = {ry_in, qy_in[NW-1]};
            assign gex = (tx >= {1'b0, d_in});
            assign gey = (ty >= {1'b0, d_in});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rx[g]  <= gex ? DW'(tx - {1'b0, d_in}) : tx[DW-1:0];
                    r_ry[g]  <= gey ? DW'(ty - {1'b0, d_in}) : ty[DW-1:0];
                    r_qx[g]  <= {qx_in[NW-2:0], gex};
                    r_qy[g]  <= {qy_in[NW-2:0], gey};
                    r_d[g]   <= d_in;
                    r_tag[g] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_valid      = r_v[NW-1];
    assign o_quo_x      = r_qx[NW-1];
    assign o_quo_y      = r_qy[NW-1];
    assign o_rem_zero_x = (r_rx[NW-1] == '0);
    assign o_rem_zero_y = (r_ry[NW-1] == '0);
    assign o_tag        = r_tag[NW-1];
endmodule

FILE: src/segment_lattice_intersection_unit.sv
// Segment pair intersection on the integer grid. Each word carries the two
// end points of segment A and of segment B; the block intersects the two
// lines through them with the determinant formula and returns one result
// word per input word, in order. The outcome is a hit with the crossing
// point, parallel lines (including degenerate segments), a crossing that is
// not an exact non-negative integer point, or a crossing that lies outside
// the x and y spans of either segment. Crossing coordinates read zero
// unless the outcome is a hit. The block accepts one word every cycle
// while o_stall is low. The pipeline holds five arithmetic stages, one
// exact division stage per quotient bit and the output register. The
// whole pipeline advances together, so a stalled output word holds the
// input side off until it is taken.
module segment_lattice_intersection_unit #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_WIDTH-1:0] i_ax1,
    input  logic [COORD_WIDTH-1:0] i_ay1,
    input  logic [COORD_WIDTH-1:0] i_ax2,
    input  logic [COORD_WIDTH-1:0] i_ay2,
    input  logic [COORD_WIDTH-1:0] i_bx1,
    input  logic [COORD_WIDTH-1:0] i_by1,
    input  logic [COORD_WIDTH-1:0] i_bx2,
    input  logic [COORD_WIDTH-1:0] i_by2,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_outcome,
    output logic [COORD_WIDTH-1:0] o_cross_x,
    output logic [COORD_WIDTH-1:0] o_cross_y
);
    localparam int W    = COORD_WIDTH;
    localparam int NW   = 3 * W + 3;
    localparam int DENW = 2 * W + 3;
    localparam int TW   = 4 * W + 3;

    logic            en;
    logic            f_valid, d_valid;
    logic [NW-1:0]   f_nx, f_ny, qx, qy;
    logic [DENW-1:0] f_den;
    logic [TW-1:0]   f_tag, d_tag;
    logic            rzx, rzy;

    logic            r_out_valid;
    logic [1:0]      r_outcome;
    logic [W-1:0]    r_cross_x, r_cross_y;

    logic            par, negx, negy, in_spans;
    logic [W-1:0]    xlo, xhi, ylo, yhi;
    slic_pkg::t_outcome outc;

    // The pipeline moves whenever the output word is not held by the sink.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    slic_front #(
        .COORD_WIDTH(W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax1   (i_ax1),
        .i_ay1   (i_ay1),
        .i_ax2   (i_ax2),
        .i_ay2   (i_ay2),
        .i_bx1   (i_bx1),
        .i_by1   (i_by1),
        .i_bx2   (i_bx2),
        .i_by2   (i_by2),
        .o_valid (f_valid),
        .o_num_x (f_nx),
        .o_num_y (f_ny),
        .o_den   (f_den),
        .o_tag   (f_tag)
    );

    slic_div #(
        .NW(NW),
        .DW(DENW),
        .TW(TW)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (f_valid),
        .i_num_x      (f_nx),
        .i_num_y      (f_ny),
        .i_den        (f_den),
        .i_tag        (f_tag),
        .o_valid      (d_valid),
        .o_quo_x      (qx),
        .o_quo_y      (qy),
        .o_rem_zero_x (rzx),
        .o_rem_zero_y (rzy),
        .o_tag        (d_tag)
    );

    // Classification: parallel first, then exactness and sign, then spans.
    always_comb begin
        {par, negx, negy, xlo, xhi, ylo, yhi} = d_tag;
        in_spans = (qx >= NW'(xlo)) && (qx <= NW'(xhi)) &&
                   (qy >= NW'(ylo)) && (qy <= NW'(yhi));
        priority if (par) begin
            outc = slic_pkg::OUT_PARALLEL;
        end else if (negx || negy || !rzx || !rzy) begin
            outc = slic_pkg::OUT_NOT_INT;
        end else if (!in_spans) begin
            outc = slic_pkg::OUT_OUTSIDE;
        end else begin
            outc = slic_pkg::OUT_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_outcome <= outc;
            r_cross_x <= (outc == slic_pkg::OUT_HIT) ? qx[W-1:0] : '0;
            r_cross_y <= (outc == slic_pkg::OUT_HIT) ? qy[W-1:0] : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_outcome = r_outcome;
    assign o_cross_x = r_cross_x;
    assign o_cross_y = r_cross_y;
endmodule

FILE: tb/sv/segment_crossing_checker.sv
`timescale 1ns / 1ps

module segment_crossing_checker #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_stall,
    input  logic [COORD_WIDTH-1:0] i_ax1,
    input  logic [COORD_WIDTH-1:0] i_ay1,
    input  logic [COORD_WIDTH-1:0] i_ax2,
    input  logic [COORD_WIDTH-1:0] i_ay2,
    input  logic [COORD_WIDTH-1:0] i_bx1,
    input  logic [COORD_WIDTH-1:0] i_by1,
    input  logic [COORD_WIDTH-1:0] i_bx2,
    input  logic [COORD_WIDTH-1:0] i_by2,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  logic [1:0]             o_outcome,
    input  logic [COORD_WIDTH-1:0] o_cross_x,
    input  logic [COORD_WIDTH-1:0] o_cross_y,
    output int                     o_fail_count,
    output int                     o_pending
);
    typedef struct packed {
        slic_pkg::t_outcome     outcome;
        logic [COORD_WIDTH-1:0] cx;
        logic [COORD_WIDTH-1:0] cy;
    } t_crossing;

    t_crossing crossings_due[$];

    function automatic logic within_span(longint e0, longint e1, longint v);
        return (e0 <= v && v <= e1) || (e1 <= v && v <= e0);
    endfunction

    // Exact non-negative quotient, or -1 when there is none.
    function automatic longint exact_quotient(longint num, longint den);
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num < 0 || num % den != 0) begin
            return -1;
        end
        return num / den;
    endfunction

    function automatic t_crossing intersect_segments(longint x1, longint y1,
            longint x2, longint y2, longint x3, longint y3, longint x4, longint y4);
        t_crossing r;
        longint den, c1, c2, px, py;
        r = '{slic_pkg::OUT_PARALLEL, '0, '0};
        den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        if (den == 0) begin
            return r;
        end
        c1 = x1 * y2 - y1 * x2;
        c2 = x3 * y4 - y3 * x4;
        px = exact_quotient(c1 * (x3 - x4) - (x1 - x2) * c2, den);
        py = exact_quotient(c1 * (y3 - y4) - (y1 - y2) * c2, den);
        if (px < 0 || py < 0) begin
            r.outcome = slic_pkg::OUT_NOT_INT;
        end else if (!(within_span(x1, x2, px) && within_span(y1, y2, py) &&
                       within_span(x3, x4, px) && within_span(y3, y4, py))) begin
            r.outcome = slic_pkg::OUT_OUTSIDE;
        end else begin
            r.outcome = slic_pkg::OUT_HIT;
            r.cx = px[COORD_WIDTH-1:0];
            r.cy = py[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = crossings_due.size();

    always @(posedge i_clk) begin
        t_crossing want;
        int errs;
        errs = 0;
        if (i_rst_n && i_valid && !o_stall) begin
            crossings_due.push_back(intersect_segments(i_ax1, i_ay1, i_ax2, i_ay2,
                                                       i_bx1, i_by1, i_bx2, i_by2));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossings_due.size() == 0) begin
                $error("result word with nothing expected");
                errs++;
            end else begin
                want = crossings_due.pop_front();
                if (o_outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, o_outcome);
                    errs++;
                end
                if (o_cross_x !== want.cx) begin
                    $error("cross_x: expected %0d, got %0d", want.cx, o_cross_x);
                    errs++;
                end
                if (o_cross_y !== want.cy) begin
                    $error("cross_y: expected %0d, got %0d", want.cy, o_cross_y);
                    errs++;
                end
            end
        end
        if (errs != 0) begin
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    localparam int CW = 8;
    // Pipeline depth given for the block.
    localparam int LATENCY = 3 * CW + 9;
    localparam int CYCLE_LIMIT = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [CW-1:0] i_ax1, i_ay1, i_ax2, i_ay2, i_bx1, i_by1, i_bx2, i_by2;
    logic          o_valid;
    logic          i_stall;
    logic [1:0]    o_outcome;
    logic [CW-1:0] o_cross_x, o_cross_y;
    int            fail_count;
    int            pending;
    int            cycle_count;

    segment_lattice_intersection_unit #(.COORD_WIDTH(CW)) DUT (.*);

    segment_crossing_checker #(.COORD_WIDTH(CW)) u_checker (
        .o_fail_count(fail_count), .o_pending(pending), .*
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls at random, with quiet stretches in which it never stalls.
    initial begin
        int run;
        i_stall = 1'b0;
        forever begin
            run = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120) : $urandom_range(0, 6);
            repeat (run) @(posedge i_clk);
            i_stall <= 1'b1;
            repeat (gap_length() + 1) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // The watchdog: a generous bound above the slowest correct run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Presents one word and holds it until the block takes it. The valid is
    // left high so that back-to-back words need no lowering in between.
    task automatic send_word(input logic [CW-1:0] p[8]);
        i_ax1 <= p[0]; i_ay1 <= p[1]; i_ax2 <= p[2]; i_ay2 <= p[3];
        i_bx1 <= p[4]; i_by1 <= p[5]; i_bx2 <= p[6]; i_by2 <= p[7];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_sender();
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(input int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
        logic [CW-1:0] p[8];
        p = '{CW'(ax1), CW'(ay1), CW'(ax2), CW'(ay2),
              CW'(bx1), CW'(by1), CW'(bx2), CW'(by2)};
        send_word(p);
        pause_sender();
    endtask

    // A random word shaped by kind: words built around a chosen lattice point,
    // parallel pairs, small-coordinate pairs or fully random noise.
    task automatic send_random_pair();
        logic [CW-1:0] p[8];
        int kind, px, py, dx, dy;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            // Both segments are built around (px,py), each end point offset on its own; end points stay on the grid.
            px = $urandom_range(0, 255);
            py = $urandom_range(0, 255);
            foreach (p[k]) p[k] = CW'($urandom);
            for (int s = 0; s < 2; s++) begin
                dx = $urandom_range(0, 12) - 6;
                dy = $urandom_range(0, 12) - 6;
                p[4*s]   = CW'(px - dx * $urandom_range(0, 4));
                p[4*s+1] = CW'(py - dy * $urandom_range(0, 4));
                p[4*s+2] = CW'(px + dx * $urandom_range(0, 4));
                p[4*s+3] = CW'(py + dy * $urandom_range(0, 4));
            end
        end else if (kind < 7) begin
            foreach (p[k]) p[k] = CW'($urandom);
            dx = $urandom_range(0, 20) - 10;
            dy = $urandom_range(0, 20) - 10;
            p[2] = CW'(p[0] + dx);
            p[3] = CW'(p[1] + dy);
            p[6] = CW'(p[4] + 2 * dx);
            p[7] = CW'(p[5] + 2 * dy);
        end else if (kind < 9) begin
            // Small coordinates make exact and out-of-span crossings common.
            foreach (p[k]) p[k] = CW'($urandom_range(0, 15));
        end else begin
            foreach (p[k]) p[k] = CW'($urandom);
        end
        send_word(p);
        pause_sender();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_ax1, i_ay1, i_ax2, i_ay2, i_bx1, i_by1, i_bx2, i_by2} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: a plain hit, each miss kind and the coordinate extremes.
        send_pair(0, 0, 4, 4, 0, 4, 4, 0);              // hit at (2,2)
        send_pair(0, 0, 255, 255, 0, 255, 255, 0);      // crossing at half-integers
        send_pair(0, 0, 10, 10, 1, 0, 11, 10);          // parallel lines
        send_pair(5, 5, 5, 5, 0, 0, 9, 3);              // degenerate segment
        send_pair(3, 3, 3, 3, 3, 3, 3, 3);              // both degenerate
        send_pair(0, 0, 2, 2, 10, 0, 8, 2);             // exact crossing beyond the spans
        send_pair(1, 0, 2, 1, 0, 1, 1, 3);              // crossing with negative x
        send_pair(0, 2, 1, 3, 2, 0, 3, 2);              // exact crossing at (6,8) beyond the spans
        send_pair(0, 0, 255, 0, 255, 0, 255, 255);      // hit at corner (255,0)
        send_pair(255, 255, 0, 255, 255, 0, 255, 255);  // hit at (255,255)
        send_pair(0, 0, 0, 255, 0, 0, 255, 0);          // hit at the origin
        send_pair(0, 0, 255, 255, 255, 255, 255, 0);    // hit at an end point
        send_pair(0, 5, 9, 5, 4, 0, 4, 255);            // horizontal meets vertical
        send_pair(170, 85, 85, 170, 85, 85, 170, 170);  // alternating bit patterns
        send_pair(0, 0, 3, 1, 0, 1, 3, 0);              // crossing at (1.5,0.5)

        // Wait for every result before the random phase.
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 1050; n++) begin
            send_random_pair();
        end
        i_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
